FILE: rtl/hcl_pkg.sv
// ============================================================================
// hcl_pkg
// Shared constants and types for the hop channel list generator.
// ============================================================================
package hcl_pkg;

	localparam int LIST_LENGTH = 23;
	localparam int SLOT_W      = 5;
	localparam int CHAN_W      = 7;
	localparam int BAND_CNT_W  = 4;

	localparam logic [31:0] LCG_MUL = 32'h0019_660D;
	localparam logic [31:0] LCG_ADD = 32'h3C6E_F35F;

	localparam int CHAN_SPAN = 73;
	localparam int CHAN_BASE = 3;

	// floor(2^RECIP_SHIFT / CHAN_SPAN); quotient estimate is low by at most one
	localparam int          RECIP_SHIFT = 30;
	localparam logic [23:0] RECIP       = 24'((64'd1 << RECIP_SHIFT) / CHAN_SPAN);

	localparam int BAND0_TOP = 27;
	localparam int BAND1_TOP = 51;
	localparam int BAND0_MAX = 8;
	localparam int BAND1_MAX = 7;
	localparam int BAND2_MAX = 8;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_RUN  = 2'b10
	} state_t;

	typedef struct packed {
		logic load;
		logic run;
	} cmd_t;

	typedef struct packed {
		logic done;
	} status_t;

endpackage

FILE: rtl/hcl_ctrl.sv
// ============================================================================
// hcl_ctrl
// Controller: loads a new ID, keeps the generator running until the list fills.
// ============================================================================
module hcl_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  hcl_pkg::status_t status,
	output hcl_pkg::cmd_t   cmd,
	output logic            busy
);
	import hcl_pkg::*;

	state_t state_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (start) state_q <= ST_RUN;
				end
				ST_RUN: begin
					if (status.done) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign busy     = (state_q == ST_RUN);
	assign cmd.load = (state_q == ST_IDLE) && start;
	assign cmd.run  = (state_q == ST_RUN) && !status.done;

endmodule

FILE: rtl/hcl_datapath.sv
// ============================================================================
// hcl_datapath
// Generator, mod-73 reduction pipeline and candidate filter with result regs.
// ============================================================================
module hcl_datapath (
	input  logic                          clk,
	input  logic                          arst_n,
	input  hcl_pkg::cmd_t                 cmd,
	input  logic [31:0]                   manufacturer_id,
	output hcl_pkg::status_t              status,
	output logic                          strobe,
	output logic [hcl_pkg::CHAN_W-1:0]    channel,
	output logic [hcl_pkg::SLOT_W-1:0]    slot_index,
	output logic                          last
);
	import hcl_pkg::*;

	// generator (stage 1)
	logic [31:0] gen_q;
	logic        seed_bit_q;
	logic        v_s1_q;

	// reciprocal multiply (stage 2)
	logic [47:0] prod_s2;
	logic [23:0] x_s2;
	logic        v_s2;

	// remainder estimate, 0..145 (stage 3)
	logic [7:0]  rem_s3;
	logic        v_s3;

	// list state
	logic [CHAN_SPAN-1:0]  used_q;
	logic [BAND_CNT_W-1:0] band0_q, band1_q, band2_q;
	logic [SLOT_W-1:0]     filled_q;

	// result registers
	logic              strobe_q;
	logic [CHAN_W-1:0] channel_q;
	logic [SLOT_W-1:0] slot_q;
	logic              last_q;

	logic [17:0] quot;
	logic [7:0]  rem_fix;
	logic [6:0]  ridx;
	logic [CHAN_W-1:0] ch;
	logic        par_ok, dup, band_full, not_full, take;
	logic [1:0]  band;

	assign quot = prod_s2[47:RECIP_SHIFT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1_q   <= 1'b0;
			v_s2     <= 1'b0;
			v_s3     <= 1'b0;
			used_q   <= '0;
			band0_q  <= '0;
			band1_q  <= '0;
			band2_q  <= '0;
			filled_q <= '0;
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= 1'b0;
			if (cmd.load) begin
				v_s1_q   <= 1'b0;
				v_s2     <= 1'b0;
				v_s3     <= 1'b0;
				used_q   <= '0;
				band0_q  <= '0;
				band1_q  <= '0;
				band2_q  <= '0;
				filled_q <= '0;
			end else begin
				v_s1_q <= cmd.run;
				v_s2   <= v_s1_q;
				v_s3   <= v_s2;
				if (take) begin
					used_q[ridx] <= 1'b1;
					case (band)
						2'd0:    band0_q <= band0_q + 1'b1;
						2'd1:    band1_q <= band1_q + 1'b1;
						default: band2_q <= band2_q + 1'b1;
					endcase
					filled_q <= filled_q + 1'b1;
					strobe_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			gen_q      <= ~manufacturer_id;
			seed_bit_q <= ~manufacturer_id[0];
		end else if (cmd.run) begin
			gen_q <= gen_q * LCG_MUL + LCG_ADD;
		end
		prod_s2 <= 48'(gen_q[31:8]) * 48'(RECIP);
		x_s2    <= gen_q[31:8];
		rem_s3  <= 8'(x_s2 - 24'(25'(quot) * 25'(CHAN_SPAN)));
		if (take) begin
			channel_q <= ch;
			slot_q    <= filled_q;
			last_q    <= (filled_q == SLOT_W'(LIST_LENGTH - 1));
		end
	end

	// candidate filter
	always_comb begin
		rem_fix   = (rem_s3 >= 8'(CHAN_SPAN)) ? rem_s3 - 8'(CHAN_SPAN) : rem_s3;
		ridx      = rem_fix[6:0];
		ch        = ridx + CHAN_W'(CHAN_BASE);
		par_ok    = ch[0] ^ seed_bit_q;
		dup       = used_q[ridx];
		if (ch <= CHAN_W'(BAND0_TOP)) begin
			band      = 2'd0;
			band_full = (band0_q >= BAND_CNT_W'(BAND0_MAX));
		end else if (ch <= CHAN_W'(BAND1_TOP)) begin
			band      = 2'd1;
			band_full = (band1_q >= BAND_CNT_W'(BAND1_MAX));
		end else begin
			band      = 2'd2;
			band_full = (band2_q >= BAND_CNT_W'(BAND2_MAX));
		end
		not_full  = (filled_q < SLOT_W'(LIST_LENGTH));
		take      = v_s3 && !cmd.load && not_full && par_ok && !dup && !band_full;
	end

	assign status.done = (filled_q == SLOT_W'(LIST_LENGTH));
	assign strobe      = strobe_q;
	assign channel     = channel_q;
	assign slot_index  = slot_q;
	assign last        = last_q;

endmodule

FILE: rtl/hop_channel_list_generator_core.sv
// ============================================================================
// hop_channel_list_generator_core
// Builds the 23-entry hop channel list for a manufacturer ID.
// ============================================================================
//
//  channel   direction  signals                              transfer when
//  --------  ---------  -----------------------------------  ------------------
//  command   in         start, busy, manufacturer_id         start && !busy
//  result    out        strobe, channel, slot_index, last    strobe (no stall)
//
//  The generator makes one draw per clock while a list is being built; a
//  draw passes a 3-stage reduction pipeline (generator, reciprocal multiply,
//  remainder) and is filtered in the last stage. The time an ID takes is set
//  by the reject rate. Results come out one per accepted channel, in list
//  order; busy drops at the edge that takes the last transfer. Reset is
//  asynchronous active low and clears the controller and list state. The
//  receiver cannot stall.
//
module hop_channel_list_generator_core (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  logic [31:0]                manufacturer_id,
	output logic                       strobe,
	output logic [hcl_pkg::CHAN_W-1:0] channel,
	output logic [hcl_pkg::SLOT_W-1:0] slot_index,
	output logic                       last
);
	import hcl_pkg::*;

	cmd_t    cmd;     // load a new seed / advance the generator
	status_t status;  // list full

	// Controller: idle until start, then runs the generator until done.
	hcl_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.status (status),
		.cmd    (cmd),
		.busy   (busy)
	);

	// Datapath: generator, mod-73 pipeline, duplicate mask, band counters.
	hcl_datapath u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.manufacturer_id (manufacturer_id),
		.status          (status),
		.strobe          (strobe),
		.channel         (channel),
		.slot_index      (slot_index),
		.last            (last)
	);

endmodule

FILE: rtl/hcl_checker.sv
// ============================================================================
// hcl_checker
// Port-level checks on the hop channel list generator.
// ============================================================================
module hcl_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       start,
	input logic       busy,
	input logic       strobe,
	input logic [6:0] channel,
	input logic [4:0] slot_index,
	input logic       last
);

	// results only while a list is being built
	a_strobe_busy: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> busy)
		else $error("result transfer while not busy");

	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted command did not raise busy");

	a_last_slot: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && last |-> slot_index == 5'd22)
		else $error("last flag on wrong slot");

	a_chan_range: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> channel >= 7'd3 && channel <= 7'd75)
		else $error("channel out of range");

	a_busy_end: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> $past(strobe && last))
		else $error("busy dropped without the final transfer");

endmodule

bind hop_channel_list_generator_core hcl_checker u_hcl_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.start      (start),
	.busy       (busy),
	.strobe     (strobe),
	.channel    (channel),
	.slot_index (slot_index),
	.last       (last)
);

FILE: tb/tb_top.sv
`timescale 1ns / 100ps
// ============================================================================
// tb_top
// Self-checking bench for the hop channel list generator core. IDs are
// driven over the start/busy command port. Each accepted ID is expanded
// locally into its 23-slot hop list, and every strobed result is compared
// against the oldest slot still outstanding.
// ============================================================================
module tb_top;

	import hcl_pkg::*;

	localparam int unsigned N_RANDOM   = 295;
	localparam int unsigned MAX_GAP    = 8;
	localparam int unsigned DRAIN_WAIT = 20000;  // cycles allowed for the last list
	localparam int unsigned TAIL_WAIT  = 200;    // quiet cycles after the last result
	localparam int unsigned MAX_REPORT = 10;

	// one command transfer: the ID, plus how it is presented
	typedef struct {
		logic [31:0] id;
		int unsigned gap;    // idle cycles before start is raised
		bit          drain;  // hold start until every pending slot is back
	} id_cmd_t;

	// one expected result transfer
	typedef struct {
		logic [CHAN_W-1:0] channel;
		logic [SLOT_W-1:0] slot;
		logic              last;
	} hop_slot_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              start = 1'b0;
	logic [31:0]       manufacturer_id = '0;
	logic              busy;
	logic              strobe;
	logic [CHAN_W-1:0] channel;
	logic [SLOT_W-1:0] slot_index;
	logic              last;

	id_cmd_t     id_q[$];          // IDs not yet handed to the driver
	hop_slot_t   hop_slot_q[$];    // slots predicted but not yet seen
	id_cmd_t     cur_cmd;
	bit          have_cmd = 1'b0;
	int unsigned hold_cnt = 0;
	int unsigned mismatch_cnt = 0;
	hop_slot_t   want;

	hop_channel_list_generator_core u_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (start),
		.busy            (busy),
		.manufacturer_id (manufacturer_id),
		.strobe          (strobe),
		.channel         (channel),
		.slot_index      (slot_index),
		.last            (last)
	);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	// ------------------------------------------------------------------------
	// Hop list prediction. The inverted ID seeds the LCG; each draw gives a
	// candidate (value >> 8) mod 73 + 3. Candidates are dropped on matching
	// seed parity, on repeat, or when their band is already full. State is
	// rebuilt from scratch for every ID.
	// ------------------------------------------------------------------------
	function automatic void push_hop_list(input logic [31:0] id);
		logic [31:0]       seed;
		logic [31:0]       lcg;
		logic [CHAN_W-1:0] picked[LIST_LENGTH];
		int                band_fill[3];
		int                band_cap[3];
		int                n_picked;
		int                cand;
		int                band;
		bit                seen;
		hop_slot_t         s;

		seed        = ~id;
		lcg         = seed;
		n_picked    = 0;
		band_fill   = '{0, 0, 0};
		band_cap    = '{BAND0_MAX, BAND1_MAX, BAND2_MAX};
		while (n_picked < LIST_LENGTH) begin
			lcg  = lcg * LCG_MUL + LCG_ADD;
			cand = int'((lcg >> 8) % 32'(CHAN_SPAN)) + CHAN_BASE;
			// parity must differ from the seed's bit 0
			if (cand[0] == seed[0])
				continue;
			seen = 1'b0;
			for (int k = 0; k < n_picked; k++)
				if (picked[k] == CHAN_W'(cand))
					seen = 1'b1;
			if (seen)
				continue;
			band = (cand <= BAND0_TOP) ? 0 : (cand <= BAND1_TOP) ? 1 : 2;
			if (band_fill[band] >= band_cap[band])
				continue;
			band_fill[band]++;
			picked[n_picked] = CHAN_W'(cand);
			n_picked++;
		end
		for (int k = 0; k < LIST_LENGTH; k++) begin
			s.channel = picked[k];
			s.slot    = SLOT_W'(k);
			s.last    = (k == LIST_LENGTH - 1);
			hop_slot_q.push_back(s);
		end
	endfunction

	// ------------------------------------------------------------------------
	// Driver. A transfer happens at an edge where start was high and busy
	// low; the list for that ID is predicted right there. The next command
	// is then staged: its gap is counted off with start low, and a drain
	// command also waits for the pending slots to empty. While a command is
	// being presented and busy is high, start simply stays up.
	// ------------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start           <= 1'b0;
			manufacturer_id <= '0;
			have_cmd = 1'b0;
			hold_cnt = 0;
		end else begin
			if (start && !busy) begin
				push_hop_list(manufacturer_id);
				have_cmd = 1'b0;
			end
			if (!have_cmd && id_q.size() != 0) begin
				cur_cmd  = id_q.pop_front();
				have_cmd = 1'b1;
				hold_cnt = cur_cmd.gap;
			end
			if (!have_cmd) begin
				start <= 1'b0;
			end else if (!(start && busy)) begin
				if (hold_cnt != 0) begin
					start    <= 1'b0;
					hold_cnt = hold_cnt - 1;
				end else if (cur_cmd.drain && hop_slot_q.size() != 0) begin
					start <= 1'b0;
				end else begin
					start           <= 1'b1;
					manufacturer_id <= cur_cmd.id;
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// Monitor. Results cannot be stalled, so every strobe is a transfer and
	// is checked against the oldest predicted slot.
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n && strobe) begin
			if (hop_slot_q.size() == 0) begin
				mismatch_cnt <= mismatch_cnt + 1;
				if (mismatch_cnt < MAX_REPORT)
					$display("[%0t] unexpected result: channel=%0d slot=%0d last=%0b",
						$realtime, channel, slot_index, last);
			end else begin
				want = hop_slot_q.pop_front();
				if (channel !== want.channel || slot_index !== want.slot ||
				    last !== want.last) begin
					mismatch_cnt <= mismatch_cnt + 1;
					if (mismatch_cnt < MAX_REPORT)
						$display({"[%0t] mismatch: exp channel=%0d slot=%0d last=%0b,",
							" got channel=%0d slot=%0d last=%0b"}, $realtime,
							want.channel, want.slot, want.last,
							channel, slot_index, last);
				end
			end
		end
	end

	function automatic void queue_id(input logic [31:0] id, input int unsigned gap,
		input bit drain);
		id_cmd_t c;

		c.id    = id;
		c.gap   = gap;
		c.drain = drain;
		id_q.push_back(c);
	endfunction

	// ------------------------------------------------------------------------
	// Stimulus and end of run.
	// ------------------------------------------------------------------------
	initial begin
		int unsigned wait_cnt;
		int unsigned gap;

		// directed: extremes, both seed parities, single-bit and alternating
		// patterns, and a repeated ID to show nothing is carried over
		queue_id(32'h0000_0000, 0, 1'b0);
		queue_id(32'hFFFF_FFFF, 0, 1'b0);
		queue_id(32'h0000_0001, 3, 1'b0);
		queue_id(32'hFFFF_FFFE, 0, 1'b0);
		queue_id(32'h8000_0000, 8, 1'b0);
		queue_id(32'h7FFF_FFFF, 0, 1'b1);
		queue_id(32'hAAAA_AAAA, 1, 1'b0);
		queue_id(32'h5555_5555, 0, 1'b0);
		queue_id(32'h0100_0000, 2, 1'b0);
		queue_id(32'h0001_0000, 0, 1'b0);
		queue_id(32'h0000_0100, 5, 1'b0);
		queue_id(32'h1234_5678, 0, 1'b0);
		queue_id(32'h1234_5678, 0, 1'b0);
		queue_id(32'hDEAD_BEEF, 4, 1'b1);
		queue_id(32'h0000_0000, 0, 1'b0);

		for (int unsigned i = 0; i < N_RANDOM; i++) begin
			// a stretch of back-to-back commands, otherwise random gaps
			gap = (i >= 100 && i < 140) ? 0 : $urandom_range(0, MAX_GAP);
			queue_id($urandom, gap, (i % 60) == 59);
		end

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		while (id_q.size() != 0 || have_cmd)
			@(posedge clk);
		wait_cnt = 0;
		while (hop_slot_q.size() != 0 && wait_cnt < DRAIN_WAIT) begin
			@(posedge clk);
			wait_cnt++;
		end
		repeat (TAIL_WAIT) @(posedge clk);

		if (hop_slot_q.size() != 0)
			$display("%0d predicted slots never arrived", hop_slot_q.size());
		if (mismatch_cnt == 0 && hop_slot_q.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	// hard stop well beyond the slowest legal run
	initial begin
		#10ms;
		$display("CHECK FAILED");
		$finish;
	end

endmodule

FILE: files.f
rtl/hcl_pkg.sv
rtl/hcl_ctrl.sv
rtl/hcl_datapath.sv
rtl/hop_channel_list_generator_core.sv
rtl/hcl_checker.sv
tb/tb_top.sv
